// ===== hw/rtl/scfd_pkg.sv =====
// Shared types, character codes and message tables for the serial command frame decoder.
`timescale 1ns / 1ps

package scfd_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t CH_S_LOW  = 8'h73;
    localparam byte_t CH_T_LOW  = 8'h74;
    localparam byte_t CH_P_LOW  = 8'h70;
    localparam byte_t CH_A      = 8'h41;
    localparam byte_t CH_D      = 8'h44;
    localparam byte_t CH_L      = 8'h4C;
    localparam byte_t CH_M      = 8'h4D;
    localparam byte_t CH_O      = 8'h4F;
    localparam byte_t CH_R      = 8'h52;
    localparam byte_t CH_S      = 8'h53;
    localparam byte_t CH_ONE    = 8'h31;
    localparam byte_t CH_EIGHT  = 8'h38;

    localparam logic [3:0] HDR_FIRST   = 4'd1;
    localparam logic [3:0] HDR_LAST    = 4'd14;
    localparam logic [4:0] PWD_LEN     = 5'd3;
    localparam logic [4:0] ECHO_MAX    = 5'd13;
    localparam logic [4:0] NOMATCH_LEN = 5'd11;
    localparam logic [4:0] ALARM_LEN   = 5'd9;
    localparam logic [4:0] MAX_RESULTS = 5'd16;

    localparam logic [1:0] ALARM_ARM = 2'd0;
    localparam logic [1:0] ALARM_DRM = 2'd1;
    localparam logic [1:0] ALARM_SOS = 2'd2;

    typedef struct packed {
        logic accept;
        logic gather;
        logic decide;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic byte_is_t;
        logic gather_done;
        logic emit_done;
    } ctrl_sts_t;

    // "PWD"
    function automatic byte_t pwd_char(input logic [1:0] k);
        byte_t c;
        case (k)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h57;
            2'd2:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "\n not match"
    function automatic byte_t nomatch_char(input logic [3:0] k);
        byte_t c;
        case (k)
            4'd0:    c = 8'h0A;
            4'd1:    c = 8'h20;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h6F;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h6D;
            4'd7:    c = 8'h61;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h63;
            4'd10:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "SSGP0n" follows the three password bytes
    function automatic byte_t alarm_char(input logic [3:0] k, input logic [1:0] code);
        byte_t c;
        case (k)
            4'd3:    c = 8'h53;
            4'd4:    c = 8'h53;
            4'd5:    c = 8'h47;
            4'd6:    c = 8'h50;
            4'd7:    c = 8'h30;
            4'd8:    c = CH_ONE + {6'd0, code};
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/scfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/scfd_ctrl.sv =====
// Controller state machine: accept, header gather, decode and result emission.
`timescale 1ns / 1ps

module scfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output scfd_pkg::ctrl_cmd_t  cmd,
    input  scfd_pkg::ctrl_sts_t  sts
);

    import scfd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = sts.byte_is_t ? ST_GATHER : ST_EMIT;
                end
            end
            ST_GATHER:
            begin
                cmd.gather = 1'b1;
                if (sts.gather_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/scfd_datapath.sv =====
// Datapath: frame buffer, password, lights, frame decode and result register.
`timescale 1ns / 1ps

module scfd_datapath #(
    parameter int FRAME_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           s_tdata,
    input  scfd_pkg::ctrl_cmd_t  cmd,
    output scfd_pkg::ctrl_sts_t  sts,
    input  logic                 cfg_wen,
    input  logic                 cfg_wdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast
);

    import scfd_pkg::*;

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int WPW = $clog2(FRAME_BYTES + 1);
    localparam logic [WPW-1:0] WP_LIMIT = WPW'(FRAME_BYTES);
    localparam logic [WPW-1:0] WP_ONE   = WPW'(1);
    localparam logic [WPW-1:0] WP_TWO   = WPW'(2);
    localparam logic [WPW-1:0] WP_THREE = WPW'(3);
    localparam logic [WPW-1:0] WP_FOUR  = WPW'(4);

    localparam logic [1:0] MSG_NONE    = 2'd0;
    localparam logic [1:0] MSG_LEARN   = 2'd1;
    localparam logic [1:0] MSG_NOMATCH = 2'd2;
    localparam logic [1:0] MSG_ALARM   = 2'd3;

    logic [WPW-1:0]         wp_reg;
    logic [WPW-1:0]         wp_next;
    logic [WPW-1:0]         end_reg;
    logic [FRAME_BYTES-1:0] vld_reg;
    logic                   learn_mode_reg;
    byte_t                  pw_reg [0:2];
    byte_t                  pw_next [0:2];
    logic [7:0]             lights_reg;
    logic [7:0]             lights_next;
    logic [3:0]             rd_idx_reg;
    logic                   pend_reg;
    logic [3:0]             pidx_reg;
    logic                   pvld_reg;
    byte_t                  hdr_reg [1:14];
    logic [1:0]             msg_reg;
    logic [1:0]             msg_next;
    logic [4:0]             cnt_reg;
    logic [4:0]             cnt_next;
    logic [1:0]             alarm_reg;
    logic [1:0]             alarm_next;
    logic                   alarm_vld_reg;
    logic                   alarm_vld_next;
    logic [3:0]             k_reg;
    logic                   out_vld_reg;
    logic [19:0]            out_data_reg;
    logic                   out_last_reg;

    logic                   byte_s;
    logic                   byte_t_hit;
    logic                   wr_en;
    logic                   rd_en;
    logic                   rd_in_range;
    byte_t                  ram_q;
    logic [WPW-1:0]         echo_n;
    logic                   pw_match;
    byte_t                  emit_byte;
    logic                   emit_last;
    logic                   out_free;
    logic                   push;

    assign byte_s      = (s_tdata == CH_S_LOW);
    assign byte_t_hit  = (s_tdata == CH_T_LOW);
    assign wr_en       = cmd.accept && !byte_s && (wp_reg < WP_LIMIT);
    assign rd_en       = cmd.gather && (rd_idx_reg <= HDR_LAST);
    assign rd_in_range = (WPW'(rd_idx_reg) < WP_LIMIT);

    scfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(wp_reg)),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (AW'(rd_idx_reg)),
        .rdata (ram_q)
    );

    always_comb
    begin
        wp_next = wp_reg;
        if (byte_s || byte_t_hit)
        begin
            wp_next = WP_ONE;
        end
        else if (wp_reg < WP_LIMIT)
        begin
            wp_next = wp_reg + WP_ONE;
        end
    end

    // frame decode from the gathered header bytes
    assign pw_match = (hdr_reg[1] == pw_reg[0]) && (hdr_reg[2] == pw_reg[1]) &&
                      (hdr_reg[3] == pw_reg[2]);
    assign echo_n   = (end_reg > WP_TWO) ? (end_reg - WP_TWO) : '0;

    always_comb
    begin
        pw_next        = pw_reg;
        lights_next    = lights_reg;
        msg_next       = MSG_NONE;
        cnt_next       = '0;
        alarm_next     = ALARM_ARM;
        alarm_vld_next = 1'b0;
        if (learn_mode_reg)
        begin
            msg_next = MSG_LEARN;
            if (echo_n >= WPW'(ECHO_MAX))
            begin
                cnt_next = MAX_RESULTS;
            end
            else
            begin
                cnt_next = 5'(echo_n) + PWD_LEN;
            end
            if (hdr_reg[1] == CH_P_LOW)
            begin
                if (WP_TWO <= end_reg)
                begin
                    pw_next[0] = hdr_reg[2];
                end
                if (WP_THREE <= end_reg)
                begin
                    pw_next[1] = hdr_reg[3];
                end
                if (WP_FOUR <= end_reg)
                begin
                    pw_next[2] = hdr_reg[4];
                end
            end
        end
        else if (!pw_match)
        begin
            msg_next = MSG_NOMATCH;
            cnt_next = NOMATCH_LEN;
        end
        else if (hdr_reg[4] == CH_A)
        begin
            if ((hdr_reg[7] == CH_L) && (hdr_reg[8] inside {[CH_ONE:CH_EIGHT]}))
            begin
                lights_next[3'(hdr_reg[8] - CH_ONE)] = ~lights_reg[3'(hdr_reg[8] - CH_ONE)];
            end
        end
        else if (hdr_reg[4] == CH_S)
        begin
            if ((hdr_reg[8] == CH_A) && (hdr_reg[9] == CH_R) && (hdr_reg[10] == CH_M))
            begin
                msg_next       = MSG_ALARM;
                cnt_next       = ALARM_LEN;
                alarm_next     = ALARM_ARM;
                alarm_vld_next = 1'b1;
            end
            else if ((hdr_reg[8] == CH_D) && (hdr_reg[9] == CH_R) && (hdr_reg[10] == CH_M))
            begin
                msg_next       = MSG_ALARM;
                cnt_next       = ALARM_LEN;
                alarm_next     = ALARM_DRM;
                alarm_vld_next = 1'b1;
            end
            else if ((hdr_reg[8] == CH_S) && (hdr_reg[9] == CH_O) && (hdr_reg[10] == CH_S))
            begin
                msg_next       = MSG_ALARM;
                cnt_next       = ALARM_LEN;
                alarm_next     = ALARM_SOS;
                alarm_vld_next = 1'b1;
            end
        end
    end

    // result byte for step k of the current message
    always_comb
    begin
        case (msg_reg)
            MSG_LEARN:
            begin
                emit_byte = (k_reg < 4'd3) ? pwd_char(k_reg[1:0]) : hdr_reg[k_reg - 4'd1];
            end
            MSG_NOMATCH:
            begin
                emit_byte = nomatch_char(k_reg);
            end
            MSG_ALARM:
            begin
                emit_byte = (k_reg < 4'd3) ? pw_reg[k_reg[1:0]] : alarm_char(k_reg, alarm_reg);
            end
            default:
            begin
                emit_byte = 8'h00;
            end
        endcase
    end

    assign emit_last = (cnt_reg == 5'd0) || ((5'(k_reg) + 5'd1) == cnt_reg);
    assign out_free  = !out_vld_reg || m_tready;
    assign push      = cmd.emit && out_free;

    assign sts.byte_is_t   = byte_t_hit;
    assign sts.gather_done = pend_reg && (pidx_reg == HDR_LAST);
    assign sts.emit_done   = push && emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            end_reg        <= '0;
            vld_reg        <= '0;
            learn_mode_reg <= 1'b0;
            pw_reg[0]      <= '0;
            pw_reg[1]      <= '0;
            pw_reg[2]      <= '0;
            lights_reg     <= '0;
            rd_idx_reg     <= HDR_FIRST;
            pend_reg       <= 1'b0;
            pidx_reg       <= HDR_FIRST;
            pvld_reg       <= 1'b0;
            msg_reg        <= MSG_NONE;
            cnt_reg        <= '0;
            alarm_reg      <= ALARM_ARM;
            alarm_vld_reg  <= 1'b0;
            k_reg          <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                learn_mode_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                vld_reg[AW'(wp_reg)] <= 1'b1;
            end
            if (cmd.accept)
            begin
                wp_reg        <= wp_next;
                end_reg       <= wp_reg;
                rd_idx_reg    <= HDR_FIRST;
                msg_reg       <= MSG_NONE;
                cnt_reg       <= '0;
                alarm_reg     <= ALARM_ARM;
                alarm_vld_reg <= 1'b0;
                k_reg         <= '0;
            end
            pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + 4'd1;
                pidx_reg   <= rd_idx_reg;
                pvld_reg   <= rd_in_range && vld_reg[AW'(rd_idx_reg)];
            end
            if (cmd.decide)
            begin
                pw_reg        <= pw_next;
                lights_reg    <= lights_next;
                msg_reg       <= msg_next;
                cnt_reg       <= cnt_next;
                alarm_reg     <= alarm_next;
                alarm_vld_reg <= alarm_vld_next;
                k_reg         <= '0;
            end
            if (push)
            begin
                k_reg       <= k_reg + 4'd1;
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            hdr_reg[pidx_reg] <= pvld_reg ? ram_q : 8'h00;
        end
        if (push)
        begin
            out_data_reg <= {lights_reg, alarm_vld_reg, alarm_reg, (cnt_reg != 5'd0),
                             (cnt_reg != 5'd0) ? emit_byte : 8'h00};
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/serial_command_frame_decoder_top.sv =====
// Top level of the serial command frame decoder.
// A byte other than 't' yields a single result via the emit state and output register.
// A 't' byte gathers 14 header bytes, decodes, then emits N results at one per cycle
// while m_tready does not stall them; the next byte is taken only after the last one.
// Throughput is set by the gather on the RAM's single read port and by the emission.
// Reset (rst_n low, asynchronous) clears buffer valid bits, password, lights and mode.
`timescale 1ns / 1ps

module serial_command_frame_decoder_top #(
    parameter int FRAME_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [8] tx_valid, [10:9] alarm_code,
                                   // [11] alarm_valid, [19:12] lights, [23:20] zero
    output logic        m_tlast,   // last
    input  logic        cfg_wen,
    input  logic        cfg_wdata  // learn_mode
);

    import scfd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    scfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    scfd_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.gather, cmd.decide, cmd.emit}))
        else $error("controller issued more than one command");

    a_plain_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && !sts.byte_is_t |=> cmd.emit)
        else $error("non-terminating byte did not go straight to emission");

    a_gather_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        sts.gather_done |=> cmd.decide)
        else $error("header gather did not hand over to decode");

    a_silent_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tlast)
        else $error("result without a byte to send is not the final one");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking stream testbench for the serial command frame decoder top level.
`timescale 1ns / 1ps

module tb_top;
    import scfd_pkg::*;

    localparam int          FRAME_LEN   = 16;
    localparam int          SETTLE      = 40;
    localparam int          RAND_ITEMS  = 230;
    localparam int          QUIET_TAIL  = 50;
    localparam int          HOLD_AT     = 120;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          DIR_ROWS    = 27;

    typedef struct packed {
        byte_t      tx_byte;
        logic       tx_valid;
        logic [1:0] alarm_code;
        logic       alarm_valid;
        byte_t      lights;
        logic       last;
    } tx_result_t;

    typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        byte_t     data;
        logic      typed;
    } stim_row_t;

    typedef enum int {
        FR_PWD, FR_PWD_SHORT, FR_PWD_LONG, FR_NO_P,
        FR_LIGHT, FR_ALARM, FR_BAD_PWD, FR_LONG, FR_SHORT, FR_NOISE
    } frame_kind_e;

    localparam tx_result_t IDLE_RESULT = '{tx_byte: 8'h00, tx_valid: 1'b0, alarm_code: 2'd0,
                                           alarm_valid: 1'b0, lights: 8'h00, last: 1'b1};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [7:0] tx_byte, [8] tx_valid, [10:9] alarm_code,
                                      // [11] alarm_valid, [19:12] lights, [23:20] zero
    logic        m_tlast;             // last
    logic        cfg_wen   = 1'b0;
    logic        cfg_wdata = 1'b0;

    byte_t       frame_mem [FRAME_LEN];
    int unsigned wr_pos;
    byte_t       pwd [3];
    byte_t       light_st;
    logic        learn_st;
    byte_t       tx_msg [$];
    tx_result_t  step_q [$];
    tx_result_t  exp_q [$];
    byte_t       frame_seq [$];

    string       alarm_word [3]    = '{"ARM", "DRM", "SOS"};
    logic [1:0]  alarm_code_of [3] = '{ALARM_ARM, ALARM_DRM, ALARM_SOS};

    logic        quiet      = 1'b0;
    logic        hold_done  = 1'b0;
    int          hold_left  = 0;
    int          stall_left = 0;
    int          n_requests = 0;
    int          n_results  = 0;
    int          n_alarms   = 0;
    int          n_cfg      = 0;
    int          n_errors   = 0;
    int unsigned n_cycles   = 0;

    stim_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_MODE, 8'h01,    1'b0},
        '{ROW_BYTE, CH_S_LOW, 1'b1},
        '{ROW_BYTE, CH_P_LOW, 1'b1},
        '{ROW_BYTE, 8'h00,    1'b1},
        '{ROW_BYTE, 8'hFF,    1'b1},
        '{ROW_BYTE, 8'h80,    1'b1},
        '{ROW_BYTE, CH_L,     1'b1},
        '{ROW_BYTE, CH_ONE,   1'b1},
        '{ROW_BYTE, CH_S,     1'b1},
        '{ROW_BYTE, CH_A,     1'b1},
        '{ROW_BYTE, CH_R,     1'b1},
        '{ROW_BYTE, CH_M,     1'b1},
        '{ROW_BYTE, CH_D,     1'b1},
        '{ROW_BYTE, CH_O,     1'b1},
        '{ROW_BYTE, 8'h7F,    1'b1},
        '{ROW_BYTE, 8'h01,    1'b1},
        '{ROW_BYTE, 8'h55,    1'b1},
        '{ROW_BYTE, 8'hAA,    1'b1},
        '{ROW_BYTE, CH_T_LOW, 1'b0},
        '{ROW_MODE, 8'h00,    1'b0},
        '{ROW_BYTE, CH_S_LOW, 1'b1},
        '{ROW_BYTE, 8'h00,    1'b1},
        '{ROW_BYTE, 8'hFF,    1'b1},
        '{ROW_BYTE, 8'h80,    1'b1},
        '{ROW_BYTE, CH_S,     1'b1},
        '{ROW_BYTE, CH_T_LOW, 1'b0},
        '{ROW_BYTE, CH_T_LOW, 1'b0}
    };

    serial_command_frame_decoder_top #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic byte_t frame_at(input int unsigned i);
        return (i < FRAME_LEN) ? frame_mem[i] : 8'h00;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_msg.push_back(byte_t'(s[i]));
    endfunction

    function automatic void decode_byte(input byte_t c);
        int          alarm;
        int unsigned fin;
        int unsigned n;
        byte_t       d;
        string       w;
        alarm = -1;
        tx_msg.delete();
        step_q.delete();
        if (c == CH_S_LOW)
        begin
            wr_pos = 1;
        end
        else
        begin
            if (wr_pos < FRAME_LEN)
                frame_mem[wr_pos] = c;
            if (c == CH_T_LOW)
            begin
                fin = wr_pos;
                if (learn_st)
                begin
                    push_text("PWD");
                    for (int unsigned i = 2; i < fin; i++)
                        tx_msg.push_back(frame_at(i));
                    if (frame_at(1) == CH_P_LOW)
                        for (int unsigned i = 2; i <= fin && i <= 4; i++)
                            pwd[i - 2] = frame_at(i);
                end
                else if (frame_at(1) != pwd[0] || frame_at(2) != pwd[1] ||
                         frame_at(3) != pwd[2])
                begin
                    push_text("\n not match");
                end
                else if (frame_at(4) == CH_A)
                begin
                    d = frame_at(8);
                    if (frame_at(7) == CH_L && d >= CH_ONE && d <= CH_EIGHT)
                        light_st ^= byte_t'(1 << (d - CH_ONE));
                end
                else if (frame_at(4) == CH_S)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        w = alarm_word[k];
                        if (frame_at(8) == byte_t'(w[0]) && frame_at(9) == byte_t'(w[1]) &&
                            frame_at(10) == byte_t'(w[2]))
                        begin
                            tx_msg.push_back(pwd[0]);
                            tx_msg.push_back(pwd[1]);
                            tx_msg.push_back(pwd[2]);
                            push_text("SSGP0");
                            tx_msg.push_back(CH_ONE + byte_t'(k));
                            alarm = k;
                        end
                    end
                end
                wr_pos = 0;
            end
            if (wr_pos < FRAME_LEN)
                wr_pos++;
        end
        if (tx_msg.size() == 0)
            n = 1;
        else
            n = (tx_msg.size() > MAX_RESULTS) ? MAX_RESULTS : tx_msg.size();
        for (int unsigned k = 0; k < n; k++)
            step_q.push_back('{tx_byte: (tx_msg.size() != 0) ? tx_msg[k] : 8'h00,
                               tx_valid: tx_msg.size() != 0,
                               alarm_code: (alarm >= 0) ? alarm_code_of[alarm] : 2'd0,
                               alarm_valid: alarm >= 0,
                               lights: light_st,
                               last: k == n - 1});
    endfunction

    function automatic byte_t plain_byte();
        byte_t b;
        do
            b = byte_t'($urandom_range(0, 255));
        while (b == CH_S_LOW || b == CH_T_LOW);
        return b;
    endfunction

    function automatic void push_plain(input int unsigned cnt);
        repeat (cnt) frame_seq.push_back(plain_byte());
    endfunction

    function automatic void build_frame(input frame_kind_e kind);
        int unsigned k;
        string       w;
        frame_seq.delete();
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(3, 10)) frame_seq.push_back(byte_t'($urandom_range(0, 255)));
            return;
        end
        frame_seq.push_back(CH_S_LOW);
        case (kind)
            FR_PWD:
            begin
                frame_seq.push_back(CH_P_LOW);
                push_plain(3 + $urandom_range(0, 8));
            end
            FR_PWD_SHORT:
            begin
                frame_seq.push_back(CH_P_LOW);
                push_plain($urandom_range(0, 2));
            end
            FR_PWD_LONG:
            begin
                frame_seq.push_back(CH_P_LOW);
                push_plain($urandom_range(13, 18));
            end
            FR_NO_P:
                push_plain($urandom_range(1, 7));
            FR_LIGHT:
            begin
                frame_seq.push_back(pwd[0]);
                frame_seq.push_back(pwd[1]);
                frame_seq.push_back(pwd[2]);
                frame_seq.push_back(CH_A);
                push_plain(2);
                frame_seq.push_back(($urandom_range(0, 4) == 0) ? plain_byte() : CH_L);
                frame_seq.push_back(($urandom_range(0, 4) == 0) ? plain_byte()
                                    : CH_ONE + byte_t'($urandom_range(0, 7)));
            end
            FR_ALARM:
            begin
                frame_seq.push_back(pwd[0]);
                frame_seq.push_back(pwd[1]);
                frame_seq.push_back(pwd[2]);
                frame_seq.push_back(CH_S);
                push_plain(3);
                k = $urandom_range(0, 3);
                if (k < 3)
                begin
                    w = alarm_word[k];
                    for (int i = 0; i < 3; i++)
                        frame_seq.push_back(byte_t'(w[i]));
                end
                else
                begin
                    push_plain(3);
                end
                push_plain($urandom_range(0, 2));
            end
            FR_BAD_PWD:
            begin
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++)
                    frame_seq.push_back((i == k) ? pwd[i] ^ byte_t'(1 << $urandom_range(0, 7))
                                                 : pwd[i]);
                frame_seq.push_back(($urandom_range(0, 1) == 0) ? CH_A : CH_S);
                push_plain($urandom_range(0, 8));
            end
            FR_LONG:
                push_plain($urandom_range(13, 18));
            default:
                push_plain($urandom_range(0, 3));
        endcase
        frame_seq.push_back(CH_T_LOW);
    endfunction

    task automatic idle_sender();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input byte_t b, input logic typed);
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b);
        if (typed)
            exp_q.push_back(IDLE_RESULT);
        else
            foreach (step_q[k])
                exp_q.push_back(step_q[k]);
        n_requests++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(input logic v);
        wait_drained();
        cfg_wdata <= v;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        learn_st = v;
        n_cfg++;
    endtask

    task automatic send_frame();
        foreach (frame_seq[k])
        begin
            idle_sender();
            send_byte(frame_seq[k], 1'b0);
        end
    endtask

    // hold off the result side at random, and once for a long stretch
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && n_requests >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        tx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (m_tdata[11])
                n_alarms++;
            if (exp_q.size() == 0)
            begin
                $error("unexpected result: tx_byte 0x%0h, last %0b", m_tdata[7:0], m_tlast);
                n_errors++;
            end
            else
            begin
                want = exp_q.pop_front();
                check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
                check_field("tx_valid", 8'(want.tx_valid), 8'(m_tdata[8]));
                check_field("alarm_code", 8'(want.alarm_code), 8'(m_tdata[10:9]));
                check_field("alarm_valid", 8'(want.alarm_valid), 8'(m_tdata[11]));
                check_field("lights", want.lights, m_tdata[19:12]);
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    initial
    begin
        while (n_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n_cycles++;
        end
        $display("run timed out after %0d cycles", n_cycles);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int          n_rand;
        int          budget;
        int          sent;
        int          r;
        int          n_dir;
        logic        learn_phase;
        frame_kind_e kind;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        foreach (pwd[i])
            pwd[i] = 8'h00;
        wr_pos      = 0;
        light_st    = 8'h00;
        learn_st    = 1'b0;
        n_rand      = 0;
        learn_phase = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_MODE)
            begin
                set_mode(dir_tab[i].data[0]);
            end
            else
            begin
                idle_sender();
                send_byte(dir_tab[i].data, dir_tab[i].typed);
            end
        end
        n_dir = n_requests;

        while (n_rand < RAND_ITEMS)
        begin
            set_mode(learn_phase);
            budget = learn_phase ? 18 : 50;
            sent   = 0;
            while (sent < budget)
            begin
                quiet = (n_rand + sent >= RAND_ITEMS - QUIET_TAIL);
                r = $urandom_range(0, 9);
                if (learn_phase)
                    kind = (r <= 5) ? FR_PWD : (r == 6) ? FR_PWD_SHORT :
                           (r == 7) ? FR_PWD_LONG : (r == 8) ? FR_NOISE : FR_NO_P;
                else
                    kind = (r <= 2) ? FR_LIGHT : (r <= 5) ? FR_ALARM : (r == 6) ? FR_BAD_PWD :
                           (r == 7) ? FR_NOISE : (r == 8) ? FR_LONG : FR_SHORT;
                build_frame(kind);
                send_frame();
                sent += frame_seq.size();
            end
            // leave a usable password for the next operate phase
            if (learn_phase)
            begin
                build_frame(FR_PWD);
                send_frame();
                sent += frame_seq.size();
            end
            n_rand += sent;
            learn_phase = !learn_phase;
        end

        wait_drained();
        if (exp_q.size() != 0)
        begin
            $error("%0d expected results never arrived", exp_q.size());
            n_errors++;
        end
        $display("Covered %0d requests (%0d from the directed table) and %0d results,",
                 n_requests, n_dir, n_results);
        $display("with %0d mode writes, %0d alarm results and lights ending at 0x%0h.",
                 n_cfg, n_alarms, light_st);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
